// File: design/dq_pkg.sv
// Shared types, constants and pointer helpers for the double-ended queue unit.
`default_nettype none

package dq_pkg;

  // Store geometry.
  localparam int DEPTH   = 16;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;

  // Fixed field widths of the items.
  localparam int ACT_W   = 3;
  localparam int POS_W   = 6;
  localparam int OCC_W   = 7;
  localparam int STAT_W  = 2;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE_BACK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE_FRONT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DUMP         = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  element;
    logic [POS_W-1:0]    position;
    logic [OCC_W-1:0]    occupancy;
    logic [STAT_W-1:0]   status;
    logic                last;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } dq_state_t;

  // Step a pointer forward by one around the circular store.
  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  // Step a pointer back by one around the circular store.
  function automatic ptr_t ptr_dec(input ptr_t p);
    ptr_t r;
    if (p == '0) begin
      r = PTR_W'(DEPTH - 1);
    end else begin
      r = p - ptr_t'(1);
    end
    return r;
  endfunction

  // Add a count (at most DEPTH) to a pointer and wrap once.
  function automatic ptr_t ptr_add(input ptr_t p, input cnt_t c);
    logic [CNT_W:0] s;
    logic [CNT_W:0] w;
    s = (CNT_W + 1)'(p) + (CNT_W + 1)'(c);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      w = s - (CNT_W + 1)'(DEPTH);
    end else begin
      w = s;
    end
    return w[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/dq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none

module dq_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: design/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: control, pointers and output register.
`default_nettype none

// A bounded double-ended queue of signed 32-bit values held in a circular
// store of dq_pkg::DEPTH entries in a synchronous RAM. An item is accepted on a
// rising edge where start is high and busy is low. Pushes and removes keep busy
// low, so one can be accepted every cycle; each gives one result whose strobe
// out_valid rises in the cycle after acceptance. A dump walks the store through
// the RAM read port, one element per cycle: busy is high from the acceptance of a
// non-empty dump until its final element has been read, and its results pass the
// RAM read register and the output register and follow on consecutive cycles,
// with last set on the final one. An empty dump, a remove on an empty queue and a
// push to a full queue each give a single status result. Undefined actions are
// swallowed with no result. The receiver cannot stall: every result is on the
// out_ ports for exactly one cycle, so it must be taken when out_valid is high.
module double_ended_queue_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire dq_pkg::in_item_t   in_item,
  output logic                    busy,
  output logic                    out_valid,
  output dq_pkg::out_item_t       out_item
);

  // Control state.
  dq_pkg::dq_state_t state_r, state_nxt;
  dq_pkg::ptr_t      front_r, front_nxt;
  dq_pkg::cnt_t      count_r, count_nxt;
  dq_pkg::ptr_t      rd_ptr_r, rd_ptr_nxt;
  dq_pkg::ptr_t      idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  dq_pkg::out_item_t out_item_r, out_item_nxt;

  // RAM ports.
  logic                      wr_en;
  dq_pkg::ptr_t              wr_addr;
  logic [dq_pkg::DATA_W-1:0] wr_data;
  dq_pkg::ptr_t              rd_addr;
  logic [dq_pkg::DATA_W-1:0] rd_data;

  logic accept;
  logic is_full;
  logic is_empty;
  logic dump_last;

  dq_ram #(
    .DATA_W (dq_pkg::DATA_W),
    .DEPTH  (dq_pkg::DEPTH),
    .ADDR_W (dq_pkg::PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy     = (state_r == dq_pkg::ST_DUMP);
  assign accept   = start && !busy;
  assign is_full  = (count_r == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign is_empty = (count_r == '0);
  // The element read this cycle is the final one when its index is count - 1.
  assign dump_last = ((dq_pkg::CNT_W'(idx_r) + dq_pkg::cnt_t'(1)) == count_r);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dq_pkg::ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rd_ptr_r    <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    wr_en         = 1'b0;
    wr_addr       = dq_pkg::ptr_add(front_r, count_r);
    wr_data       = in_item.value;
    // While idle the read port looks at the front, so a dump has its first
    // element ready on the cycle after it is accepted.
    rd_addr       = front_r;

    case (state_r)
      dq_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_item.action)
            dq_pkg::ACT_PUSH_BACK, dq_pkg::ACT_PUSH_FRONT: begin
              out_valid_nxt     = 1'b1;
              out_item_nxt.last = 1'b1;
              if (is_full) begin
                out_item_nxt.occupancy = dq_pkg::OCC_W'(count_r);
                out_item_nxt.status    = dq_pkg::STAT_FULL;
              end else begin
                wr_en = 1'b1;
                if (in_item.action == dq_pkg::ACT_PUSH_FRONT) begin
                  front_nxt = dq_pkg::ptr_dec(front_r);
                  wr_addr   = front_nxt;
                end
                count_nxt              = count_r + dq_pkg::cnt_t'(1);
                out_item_nxt.occupancy = dq_pkg::OCC_W'(count_nxt);
                out_item_nxt.status    = dq_pkg::STAT_DONE;
              end
            end
            dq_pkg::ACT_REMOVE_BACK, dq_pkg::ACT_REMOVE_FRONT: begin
              out_valid_nxt     = 1'b1;
              out_item_nxt.last = 1'b1;
              if (is_empty) begin
                out_item_nxt.status = dq_pkg::STAT_EMPTY;
              end else begin
                if (in_item.action == dq_pkg::ACT_REMOVE_FRONT) begin
                  front_nxt = dq_pkg::ptr_inc(front_r);
                end
                count_nxt              = count_r - dq_pkg::cnt_t'(1);
                out_item_nxt.occupancy = dq_pkg::OCC_W'(count_nxt);
                out_item_nxt.status    = dq_pkg::STAT_DONE;
              end
            end
            dq_pkg::ACT_DUMP: begin
              if (is_empty) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = dq_pkg::STAT_EMPTY;
                out_item_nxt.last   = 1'b1;
              end else begin
                state_nxt  = dq_pkg::ST_DUMP;
                rd_ptr_nxt = dq_pkg::ptr_inc(front_r);
                idx_nxt    = '0;
              end
            end
            default: begin
              // Undefined actions leave the state alone and give no result.
            end
          endcase
        end
      end
      dq_pkg::ST_DUMP: begin
        // rd_data holds the element at idx_r; fetch the next one meanwhile.
        rd_addr                = rd_ptr_r;
        rd_ptr_nxt             = dq_pkg::ptr_inc(rd_ptr_r);
        idx_nxt                = idx_r + dq_pkg::ptr_t'(1);
        out_valid_nxt          = 1'b1;
        out_item_nxt.element   = rd_data;
        out_item_nxt.position  = dq_pkg::POS_W'(idx_r);
        out_item_nxt.occupancy = dq_pkg::OCC_W'(count_r);
        out_item_nxt.status    = dq_pkg::STAT_DONE;
        out_item_nxt.last      = dump_last;
        if (dump_last) begin
          state_nxt = dq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: test/double_ended_queue_unit_tb.sv
// Self-checking testbench for the double-ended queue unit with its own model of the queue.
module double_ended_queue_unit_tb;
  import dq_pkg::*;

  // One pending item for the driver, with the idle cycles that come before it is offered.
  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } send_entry_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 24;
  // Random items that follow the seventeen directed ones.
  localparam int RANDOM_ITEMS = 353;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // Items still to be sent, filled once by the stimulus block before reset ends.
  send_entry_t items_to_send[$];
  // Results that the queue model says must come out, oldest first.
  out_item_t   deque_results_due[$];

  // Private copy of the queue contents, front index and element count.
  logic signed [DATA_W-1:0] model_mem [DEPTH];
  ptr_t                     model_head;
  cnt_t                     model_count;

  // Driver bookkeeping: the item currently being offered and its remaining idle cycles.
  send_entry_t current_entry;
  bit          holding = 1'b0;
  int unsigned gap_left = 0;

  int mismatch_count = 0;
  int cycle_count = 0;

  double_ended_queue_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  // Every failure goes through here: one line in the log and one more in the count.
  task automatic flag_mismatch(input string what);
    $display("ERROR at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Append one predicted result behind the ones already due.
  task automatic queue_result(input out_item_t r);
    deque_results_due.insert(deque_results_due.size(), r);
  endtask

  // Apply one accepted item to the queue model and queue up the results it must cause.
  // Pushes and removes give one result; a dump gives one result per stored element, front
  // to back, with last only on the final one. Undefined actions change nothing.
  task automatic deque_step(input in_item_t it);
    out_item_t r;
    int        k;
    r = '0;
    r.last = 1'b1;
    case (it.action)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (int'(model_count) >= DEPTH) begin
          // The store is full, so the value is dropped and flagged.
          r.status = STAT_FULL;
        end else begin
          if (it.action == ACT_PUSH_BACK) begin
            model_mem[(int'(model_head) + int'(model_count)) % DEPTH] = it.value;
          end else begin
            model_head = ptr_t'((int'(model_head) + DEPTH - 1) % DEPTH);
            model_mem[model_head] = it.value;
          end
          model_count = model_count + cnt_t'(1);
          r.status = STAT_DONE;
        end
        r.occupancy = OCC_W'(model_count);
        queue_result(r);
      end
      ACT_REMOVE_BACK, ACT_REMOVE_FRONT: begin
        if (model_count == '0) begin
          r.status = STAT_EMPTY;
        end else begin
          if (it.action == ACT_REMOVE_FRONT) begin
            model_head = ptr_t'((int'(model_head) + 1) % DEPTH);
          end
          model_count = model_count - cnt_t'(1);
          r.status = STAT_DONE;
        end
        r.occupancy = OCC_W'(model_count);
        queue_result(r);
      end
      ACT_DUMP: begin
        if (model_count == '0) begin
          r.status = STAT_EMPTY;
          queue_result(r);
        end else begin
          for (k = 0; k < int'(model_count); k++) begin
            r.element   = model_mem[(int'(model_head) + k) % DEPTH];
            r.position  = POS_W'(k);
            r.occupancy = OCC_W'(model_count);
            r.status    = STAT_DONE;
            r.last      = (k == int'(model_count) - 1);
            queue_result(r);
          end
        end
      end
      default: begin
        // Undefined actions are swallowed without a result.
      end
    endcase
  endtask

  task automatic add_item(input logic [ACT_W-1:0] act, input logic signed [31:0] val,
                          input int unsigned gap);
    send_entry_t e;
    e.item.action = act;
    e.item.value  = val;
    e.gap         = gap;
    items_to_send.insert(items_to_send.size(), e);
  endtask

  // Values lean toward the extremes now and then so that every bit is seen both ways.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'sh7FFF_FFFF;
      1: v = 32'sh8000_0000;
      2: v = 32'sh0000_0000;
      3: v = -32'sd1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Idle cycles before an item. Style 0 never idles, style 1 idles uniformly over the full
  // range, and style 2 is mostly back to back with an occasional long pause.
  function automatic int unsigned pick_gap(input int style);
    int unsigned g;
    case (style)
      0: g = 0;
      1: g = $urandom_range(0, 17);
      default: g = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    endcase
    return g;
  endfunction

  // Stimulus: a directed opening, then random phases, then the drain and the verdict.
  initial begin : stimulus
    int          sent;
    int          phase_kind;
    int          phase_len;
    int          style;
    int          n;
    int unsigned pick;
    int          push_pct;
    int          remove_pct;
    int          dump_pct;
    logic [ACT_W-1:0] act;

    model_head  = '0;
    model_count = '0;

    // Directed opening. Removes and a dump on the empty queue come first, then the value
    // extremes through both push ends, a dump of them, a further push, removes from both
    // ends, the three undefined actions, a dump, a push to the front and a final dump.
    add_item(ACT_REMOVE_BACK,  32'sd0, pick_gap(1));
    add_item(ACT_REMOVE_FRONT, 32'sd0, pick_gap(1));
    add_item(ACT_DUMP,         32'sd0, pick_gap(1));
    add_item(ACT_PUSH_BACK,    32'sh7FFF_FFFF, pick_gap(1));
    add_item(ACT_PUSH_FRONT,   32'sh8000_0000, pick_gap(0));
    add_item(ACT_PUSH_BACK,    32'sd0, pick_gap(0));
    add_item(ACT_PUSH_FRONT,   -32'sd1, pick_gap(1));
    add_item(ACT_DUMP,         32'sd0, pick_gap(0));
    add_item(ACT_PUSH_BACK,    32'sh5555_AAAA, pick_gap(0));
    add_item(ACT_REMOVE_BACK,  -32'sd1, pick_gap(1));
    add_item(ACT_REMOVE_FRONT, -32'sd1, pick_gap(0));
    add_item(3'd5,             $urandom, pick_gap(1));
    add_item(3'd6,             $urandom, pick_gap(0));
    add_item(3'd7,             -32'sd1, pick_gap(1));
    add_item(ACT_DUMP,         $urandom, pick_gap(0));
    add_item(ACT_PUSH_FRONT,   32'sh0000_0001, pick_gap(1));
    add_item(ACT_DUMP,         32'sd0, pick_gap(1));

    // Random phases. Filling phases drive the store to full and keep pushing into it,
    // draining phases empty it and keep removing, and the mixed phases walk the front
    // pointer around the circular store with dumps sprinkled in to read the contents back.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_kind = $urandom_range(0, 3);
      phase_len  = $urandom_range(10, 40);
      style      = $urandom_range(0, 2);
      case (phase_kind)
        0: begin push_pct = 82; remove_pct = 10; dump_pct = 5; end
        1: begin push_pct = 12; remove_pct = 78; dump_pct = 7; end
        2: begin push_pct = 40; remove_pct = 37; dump_pct = 20; end
        default: begin push_pct = 50; remove_pct = 20; dump_pct = 27; end
      endcase
      for (n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < push_pct) begin
          act = ($urandom_range(0, 1) == 0) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        end else if (pick < push_pct + remove_pct) begin
          act = ($urandom_range(0, 1) == 0) ? ACT_REMOVE_BACK : ACT_REMOVE_FRONT;
        end else if (pick < push_pct + remove_pct + dump_pct) begin
          act = ACT_DUMP;
        end else begin
          // A little noise: undefined actions, which the block must ignore.
          act = ACT_W'($urandom_range(5, 7));
        end
        add_item(act, pick_value(), pick_gap(style));
        sent++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every item is taken and every predicted result has come out, then give
    // the block time to show any stray result before the verdict.
    while (items_to_send.size() != 0 || holding || deque_results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (deque_results_due.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", deque_results_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("double_ended_queue_unit_tb passed");
    end else begin
      $display("double_ended_queue_unit_tb failed");
    end
    $finish;
  end

  // Driver. At each edge it first checks whether the item on the ports was just taken
  // (start high and busy low before the edge), hands that item to the model, and then
  // decides what to show next. The next start value is worked out in a variable and
  // assigned once, so start stays high through back-to-back items without a glitch.
  always @(posedge clk) begin : driver
    logic next_start;
    next_start = 1'b0;
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
    end else begin
      if (start && !busy) begin
        deque_step(in_item);
        holding = 1'b0;
      end
      if (!holding && items_to_send.size() != 0) begin
        current_entry = items_to_send.pop_front();
        holding       = 1'b1;
        gap_left      = current_entry.gap;
      end
      if (holding) begin
        if (gap_left == 0) begin
          next_start = 1'b1;
          in_item   <= current_entry.item;
        end else begin
          gap_left--;
        end
      end
      start <= next_start;
    end
  end

  // Monitor. A result is on the ports for exactly one cycle, so it is taken at every edge
  // where out_valid was high and compared field by field with the oldest prediction.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid) begin
      if (deque_results_due.size() == 0) begin
        flag_mismatch($sformatf("result with nothing predicted: %p", out_item));
      end else begin
        want = deque_results_due.pop_front();
        if (out_item.element !== want.element) begin
          flag_mismatch($sformatf("element %0d, predicted %0d", out_item.element,
                                  want.element));
        end
        if (out_item.position !== want.position) begin
          flag_mismatch($sformatf("position %0d, predicted %0d", out_item.position,
                                  want.position));
        end
        if (out_item.occupancy !== want.occupancy) begin
          flag_mismatch($sformatf("occupancy %0d, predicted %0d", out_item.occupancy,
                                  want.occupancy));
        end
        if (out_item.status !== want.status) begin
          flag_mismatch($sformatf("status %0d, predicted %0d", out_item.status,
                                  want.status));
        end
        if (out_item.last !== want.last) begin
          flag_mismatch($sformatf("last %0b, predicted %0b", out_item.last, want.last));
        end
      end
    end
  end

  // Watchdog. The slowest correct run is well under a tenth of this limit, so reaching it
  // means the block has hung or stopped producing results.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("double_ended_queue_unit_tb failed");
      $finish;
    end
  end

endmodule
